/* src/sorted_table_binary_search_core_macros.svh */
// Assertion macros for the sorted table binary search core.
// Included by the top level only; no other dependencies.
`ifndef SORTED_TABLE_BINARY_SEARCH_CORE_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STBS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define STBS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/stbs_pkg.sv */
// Shared types and constants for the sorted table binary search core.
// No dependencies; every other file but the macro header imports this package.
`default_nettype none

package stbs_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int DATA_W          = 32;
  localparam int IDX_W           = 10;
  localparam int CNT_W           = 11;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_SEARCH = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic write_en;
    logic load;
    logic rd_en;
    logic step;
    logic out_load;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bounds_empty;
    logic probe_eq;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

/* src/stbs_if.sv */
// Handshake channel interfaces: request, response and configuration write.
// Depends on stbs_pkg for the field widths.
`default_nettype none

interface stbs_req_if import stbs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic [IDX_W-1:0]         entry_index;
  logic signed [DATA_W-1:0] data_value;

  modport source (output valid, cmd, entry_index, data_value, input ready);
  modport sink   (input valid, cmd, entry_index, data_value, output ready);
endinterface

interface stbs_rsp_if import stbs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [IDX_W-1:0] match_index;

  modport source (output valid, found, match_index, input ready);
  modport sink   (input valid, found, match_index, output ready);
endinterface

interface stbs_cfg_if import stbs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

/* src/stbs_datapath.sv */
// Datapath: table memory, search bounds, probe compare, entry count register
// and response register. Depends on stbs_pkg.
`default_nettype none

module stbs_datapath import stbs_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire ctrl_t                    ctrl_i,
  output status_t                       status_o,
  input  wire logic [IDX_W-1:0]         entry_index_i,
  input  wire logic signed [DATA_W-1:0] data_value_i,
  input  wire logic                     cfg_valid_i,
  input  wire logic [CNT_W-1:0]         cfg_data_i,
  output logic                          rsp_valid_o,
  input  wire logic                     rsp_ready_i,
  output logic                          rsp_found_o,
  output logic [IDX_W-1:0]              rsp_match_index_o
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [DATA_W-1:0]        mem_q [TABLE_DEPTH];
  logic signed [DATA_W-1:0] rdata_q;
  logic signed [DATA_W-1:0] key_q;
  logic [CNT_W-1:0]         entry_count_q;
  logic [CW-1:0]            lo_q, lo_d, hi_q, hi_d;
  logic [CW-1:0]            count_clamped;
  logic [CW-1:0]            span;
  logic [CW-1:0]            mid_full;
  logic [AW-1:0]            mid_q;
  logic [AW-1:0]            match_q;
  logic                     hit_q;
  logic                     wr_in_range;
  logic                     out_valid_q;
  logic                     out_found_q;
  logic [IDX_W-1:0]         out_index_q;

  // The upper bound is kept exclusive, so the live interval is [lo, hi).
  assign count_clamped = (32'(entry_count_q) > TABLE_DEPTH) ? CW'(TABLE_DEPTH)
                                                            : CW'(entry_count_q);
  assign span     = hi_q - lo_q - CW'(1);
  assign mid_full = lo_q + (span >> 1);
  assign wr_in_range = 32'(entry_index_i) < TABLE_DEPTH;

  assign status_o.bounds_empty = !(lo_q < hi_q);
  assign status_o.probe_eq     = (rdata_q == key_q);
  assign status_o.out_busy     = out_valid_q && !rsp_ready_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.write_en && wr_in_range) begin
      mem_q[AW'(entry_index_i)] <= data_value_i;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= $signed(mem_q[AW'(mid_full)]);
    end
  end

  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (ctrl_i.load) begin
      lo_d = '0;
      hi_d = count_clamped;
    end else if (ctrl_i.step) begin
      if (rdata_q > key_q) begin
        hi_d = CW'(mid_q);
      end else if (rdata_q < key_q) begin
        lo_d = CW'(mid_q) + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
    if (ctrl_i.load) begin
      key_q   <= data_value_i;
      match_q <= '0;
    end
    if (ctrl_i.rd_en) begin
      mid_q <= AW'(mid_full);
    end
    if (ctrl_i.step && status_o.probe_eq) begin
      match_q <= mid_q;
    end
    if (ctrl_i.out_load) begin
      out_found_q <= hit_q;
      out_index_q <= IDX_W'(match_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
      hit_q         <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        entry_count_q <= cfg_data_i;
      end
      if (ctrl_i.load) begin
        hit_q <= 1'b0;
      end else if (ctrl_i.step && status_o.probe_eq) begin
        hit_q <= 1'b1;
      end
      if (ctrl_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_valid_o       = out_valid_q;
  assign rsp_found_o       = out_found_q;
  assign rsp_match_index_o = out_index_q;

endmodule

`default_nettype wire

/* src/stbs_ctrl.sv */
// Controller state machine: accepts requests and sequences the probes.
// Depends on stbs_pkg.
`default_nettype none

module stbs_ctrl import stbs_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    req_valid_i,
  input  wire logic    req_cmd_i,
  output logic         req_ready_o,
  input  wire status_t status_i,
  output ctrl_t        ctrl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ctrl_o      = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          if (req_cmd_i == CMD_SEARCH) begin
            ctrl_o.load = 1'b1;
            state_d     = ST_PROBE;
          end else begin
            ctrl_o.write_en = 1'b1;
          end
        end
      end
      ST_PROBE: begin
        if (status_i.bounds_empty) begin
          state_d = ST_DONE;
        end else begin
          ctrl_o.rd_en = 1'b1;
          state_d      = ST_CMP;
        end
      end
      ST_CMP: begin
        ctrl_o.step = 1'b1;
        state_d     = status_i.probe_eq ? ST_DONE : ST_PROBE;
      end
      ST_DONE: begin
        // Hold the result until the response register can take it.
        if (!status_i.out_busy) begin
          ctrl_o.out_load = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/sorted_table_binary_search_core.sv */
// Sorted table binary search core. A write request is written when accepted, no response.
// A search of P probes (at most log2(TABLE_DEPTH) + 1) does a table read and a compare
// per probe, then loads the response register in its final state; a matching probe goes
// there at once, else the search ends when the bounds are empty. No request is taken
// until the search is back in idle, and a held response stalls it in its final state.
// Reset clears the controller, entry count and response valid; the table is not cleared.
`default_nettype none

`include "sorted_table_binary_search_core_macros.svh"

module sorted_table_binary_search_core import stbs_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  stbs_req_if.sink   req_i,
  stbs_rsp_if.source rsp_o,
  stbs_cfg_if.sink   cfg_i
);

  ctrl_t   ctrl;
  status_t status;

  assign cfg_i.ready = 1'b1;

  stbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_cmd_i   (req_i.cmd),
    .req_ready_o (req_i.ready),
    .status_i    (status),
    .ctrl_o      (ctrl)
  );

  stbs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctrl_i            (ctrl),
    .status_o          (status),
    .entry_index_i     (req_i.entry_index),
    .data_value_i      (req_i.data_value),
    .cfg_valid_i       (cfg_i.valid),
    .cfg_data_i        (cfg_i.data),
    .rsp_valid_o       (rsp_o.valid),
    .rsp_ready_i       (rsp_o.ready),
    .rsp_found_o       (rsp_o.found),
    .rsp_match_index_o (rsp_o.match_index)
  );

  `STBS_ASSERT_IMP(a_write_on_accept, clk_i, rst_ni, ctrl.write_en,
                   req_i.valid && req_i.ready && req_i.cmd == CMD_WRITE,
                   "table write without an accepted write request")
  `STBS_ASSERT_IMP(a_port_exclusive, clk_i, rst_ni, ctrl.write_en, !ctrl.rd_en,
                   "table read and write in the same cycle")
  `STBS_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, ctrl.out_load,
                   !(rsp_o.valid && !rsp_o.ready),
                   "response overwritten before it was taken")
  `STBS_ASSERT_NXT(a_search_busy, clk_i, rst_ni,
                   req_i.valid && req_i.ready && req_i.cmd == CMD_SEARCH, !req_i.ready,
                   "request taken while a search is running")
  `STBS_ASSERT_IMP(a_miss_index_zero, clk_i, rst_ni, rsp_o.valid && !rsp_o.found,
                   rsp_o.match_index == '0, "nonzero index on a miss")

endmodule

`default_nettype wire
